[rtl/mbrot_pkg.sv]
`timescale 1ns / 1ps
package mbrot_pkg;

    localparam int FRAC_BITS  = 26;
    localparam int MAX_DIM    = 4096;
    localparam int WORD_W     = 32;
    localparam int COORD_W    = 12;
    localparam int DIM_W      = 13;
    localparam int ITER_W     = 16;
    localparam int OFFS_W     = 31;
    localparam int COLOUR_W   = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int DVD_W = COORD_W + FRAC_BITS + 1;
    localparam int DVS_W = ITER_W;
    localparam int SQ_W  = 2 * WORD_W - FRAC_BITS;

    localparam logic [COLOUR_W-1:0] GAMUT     = '1;
    localparam logic [SQ_W:0]       ESC_LIMIT = (SQ_W + 1)'(4) << FRAC_BITS;

    localparam logic [ITER_W-1:0] RST_MAX_ITER  = 16'd256;
    localparam logic [DIM_W-1:0]  RST_WIDTH     = 13'd640;
    localparam logic [DIM_W-1:0]  RST_HEIGHT    = 13'd480;
    localparam logic [OFFS_W-1:0] RST_OFFSET_RE = 31'd100663296;
    localparam logic [OFFS_W-1:0] RST_OFFSET_IM = 31'd67108864;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_ITER  = 3'd0,
        CFG_WIDTH     = 3'd1,
        CFG_HEIGHT    = 3'd2,
        CFG_OFFSET_RE = 3'd3,
        CFG_OFFSET_IM = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DSEL_COL  = 2'd0,
        DSEL_ROW  = 2'd1,
        DSEL_STEP = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic [ITER_W-1:0] max_iter;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [OFFS_W-1:0] offset_re;
        logic [OFFS_W-1:0] offset_im;
    } cfg_t;

    typedef struct packed {
        logic     load_pixel;
        logic     div_start;
        logic     div_capture;
        div_sel_t div_sel;
        logic     mul;
        logic     test;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic escaped;
        logic last;
    } sts_t;

    function automatic logic [DVS_W-1:0] sat_dim(input logic [DIM_W-1:0] d);
        logic [DVS_W-1:0] r;
        if (d == '0) begin
            r = DVS_W'(1);
        end else if (int'(d) > MAX_DIM) begin
            r = DVS_W'(MAX_DIM);
        end else begin
            r = DVS_W'(d);
        end
        return r;
    endfunction

endpackage

[rtl/mbrot_div.sv]
`timescale 1ns / 1ps
module mbrot_div
    import mbrot_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;

    always_comb begin
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = diff[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/mbrot_dpath.sv]
`timescale 1ns / 1ps
module mbrot_dpath
    import mbrot_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  cmd_t                cmd,
    output sts_t                sts,
    input  logic [COORD_W-1:0]  pixel_column,
    input  logic [COORD_W-1:0]  pixel_row,
    output logic [COLOUR_W-1:0] colour_code,
    output logic                in_set
);

    logic [COORD_W-1:0]    col_reg, row_reg;
    logic [WORD_W-1:0]     cre_reg, cim_reg;
    logic [WORD_W-1:0]     x_reg, y_reg;
    logic [COLOUR_W-1:0]   step_reg;
    logic [SQ_W-1:0]       sqx_reg, sqy_reg;
    logic [WORD_W-1:0]     xy_reg;
    logic [ITER_W-1:0]     k_reg;
    logic                  esc_reg;
    logic [COLOUR_W-1:0]   colour_reg;
    logic                  in_set_reg;

    logic [DVD_W-1:0]      dvd;
    logic [DVS_W-1:0]      dvs;
    logic                  div_done;
    logic [DVD_W-1:0]      quo;
    logic [WORD_W-1:0]     coord_re, coord_im;
    logic [WORD_W-1:0]     abs_x, abs_y;
    logic [2*WORD_W-1:0]   sqx_full, sqy_full;
    logic signed [2*WORD_W-1:0] xy_full;
    logic [SQ_W:0]         mag;
    logic                  escaped;
    logic                  last;
    logic [ITER_W-1:0]     span;
    logic [ITER_W+COLOUR_W-1:0] colour_full;

    always_comb begin
        unique case (cmd.div_sel)
            DSEL_COL: begin
                dvd = {col_reg, {(FRAC_BITS + 1){1'b0}}};
                dvs = sat_dim(cfg.width);
            end
            DSEL_ROW: begin
                dvd = {row_reg, {(FRAC_BITS + 1){1'b0}}};
                dvs = sat_dim(cfg.height);
            end
            DSEL_STEP: begin
                dvd = DVD_W'(GAMUT);
                dvs = cfg.max_iter;
            end
            default: begin
                dvd = '0;
                dvs = '0;
            end
        endcase
    end

    mbrot_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (quo)
    );

    assign coord_re = quo[WORD_W-1:0] - {cfg.offset_re[OFFS_W-1], cfg.offset_re};
    assign coord_im = quo[WORD_W-1:0] - {cfg.offset_im[OFFS_W-1], cfg.offset_im};

    assign abs_x    = x_reg[WORD_W-1] ? (~x_reg + 1'b1) : x_reg;
    assign abs_y    = y_reg[WORD_W-1] ? (~y_reg + 1'b1) : y_reg;
    assign sqx_full = (2*WORD_W)'(abs_x) * (2*WORD_W)'(abs_x);
    assign sqy_full = (2*WORD_W)'(abs_y) * (2*WORD_W)'(abs_y);
    assign xy_full  = (2*WORD_W)'($signed(x_reg)) * (2*WORD_W)'($signed(y_reg));

    assign mag     = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign escaped = mag > ESC_LIMIT;
    assign last    = (k_reg == cfg.max_iter);

    assign span        = cfg.max_iter - k_reg;
    assign colour_full = (ITER_W+COLOUR_W)'(span) * (ITER_W+COLOUR_W)'(step_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg   <= '0;
            esc_reg <= 1'b0;
        end else begin
            if (cmd.load_pixel) begin
                k_reg <= '0;
            end
            if (cmd.test) begin
                esc_reg <= escaped;
                if (!escaped) begin
                    k_reg <= k_reg + 1'b1;
                end
            end
        end
        if (cmd.load_pixel) begin
            col_reg <= pixel_column;
            row_reg <= pixel_row;
        end
        if (cmd.div_capture) begin
            unique case (cmd.div_sel)
                DSEL_COL: begin
                    cre_reg <= coord_re;
                    x_reg   <= coord_re;
                end
                DSEL_ROW: begin
                    cim_reg <= coord_im;
                    y_reg   <= coord_im;
                end
                DSEL_STEP: begin
                    step_reg <= (cfg.max_iter == '0) ? '0 : quo[COLOUR_W-1:0];
                end
                default: begin
                    step_reg <= step_reg;
                end
            endcase
        end
        if (cmd.mul) begin
            sqx_reg <= sqx_full[2*WORD_W-1:FRAC_BITS];
            sqy_reg <= sqy_full[2*WORD_W-1:FRAC_BITS];
            xy_reg  <= xy_full[FRAC_BITS-1 +: WORD_W];
        end
        if (cmd.test && !escaped) begin
            x_reg <= sqx_reg[WORD_W-1:0] - sqy_reg[WORD_W-1:0] + cre_reg;
            y_reg <= xy_reg + cim_reg;
        end
        if (cmd.out_load) begin
            colour_reg <= esc_reg ? colour_full[COLOUR_W-1:0] : '0;
            in_set_reg <= !esc_reg;
        end
    end

    assign sts.div_done = div_done;
    assign sts.escaped  = escaped;
    assign sts.last     = last;
    assign colour_code  = colour_reg;
    assign in_set       = in_set_reg;

endmodule

[rtl/mbrot_ctrl.sv]
`timescale 1ns / 1ps
module mbrot_ctrl
    import mbrot_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_DIV_GO   = 6'b000010,
        ST_DIV_WAIT = 6'b000100,
        ST_MUL      = 6'b001000,
        ST_TEST     = 6'b010000,
        ST_DONE     = 6'b100000
    } state_t;

    state_t   state_reg, state_next;
    div_sel_t sel_reg, sel_next;
    logic     out_valid_reg, out_valid_next;

    always_comb begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.div_sel    = sel_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_pixel = 1'b1;
                    sel_next       = DSEL_COL;
                    state_next     = ST_DIV_GO;
                end
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (sts.div_done) begin
                    cmd.div_capture = 1'b1;
                    if (sel_reg == DSEL_STEP) begin
                        state_next = ST_MUL;
                    end else begin
                        sel_next   = (sel_reg == DSEL_COL) ? DSEL_ROW : DSEL_STEP;
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_TEST;
            end
            ST_TEST: begin
                cmd.test = 1'b1;
                if (sts.escaped || sts.last) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sel_reg       <= DSEL_COL;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

endmodule

[rtl/mandelbrot_escape_time_pixel_core.sv]
`timescale 1ns / 1ps
// Mandelbrot escape-time colouring of one pixel per transaction. The core maps
// (column, row) to c in signed Q6.26 through a shared restoring divider that
// resolves one quotient bit per cycle; it runs three 39-bit divisions per pixel
// (column scale, row scale, colour step), one after another. Each escape test
// then first registers the squares and cross product and then compares and
// updates; the number of escape tests made is at most max_iterations+1. One
// pixel is in work at a time; a finished result waits in the output register
// while the next pixel is accepted. Configuration writes are always ready and
// take effect immediately; write them only while the core is idle.
module mandelbrot_escape_time_pixel_core
    import mbrot_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_W-1:0]    s_pixel_column,
    input  logic [COORD_W-1:0]    s_pixel_row,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COLOUR_W-1:0]   m_colour_code,
    output logic                  m_in_set,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;
    cmd_t cmd;
    sts_t sts;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MAX_ITER:  cfg_next.max_iter  = cfg_data[ITER_W-1:0];
                CFG_WIDTH:     cfg_next.width     = cfg_data[DIM_W-1:0];
                CFG_HEIGHT:    cfg_next.height    = cfg_data[DIM_W-1:0];
                CFG_OFFSET_RE: cfg_next.offset_re = cfg_data[OFFS_W-1:0];
                CFG_OFFSET_IM: cfg_next.offset_im = cfg_data[OFFS_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_iter  <= RST_MAX_ITER;
            cfg_reg.width     <= RST_WIDTH;
            cfg_reg.height    <= RST_HEIGHT;
            cfg_reg.offset_re <= RST_OFFSET_RE;
            cfg_reg.offset_im <= RST_OFFSET_IM;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;

    mbrot_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mbrot_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .cmd          (cmd),
        .sts          (sts),
        .pixel_column (s_pixel_column),
        .pixel_row    (s_pixel_row),
        .colour_code  (m_colour_code),
        .in_set       (m_in_set)
    );

    a_accept_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a pixel was still in work");

    a_div_captured: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.div_done |-> cmd.div_capture)
        else $error("divider result dropped");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("pending result overwritten");

    a_test_follows_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul |=> cmd.test)
        else $error("escape test did not follow the multiply step");

endmodule

[bench/tb_mandelbrot_escape_time_pixel_core.sv]
`timescale 1ns / 1ps
module tb_mandelbrot_escape_time_pixel_core;
    import mbrot_pkg::*;

    localparam int ONE_Q = 1 << FRAC_BITS;
    localparam logic [CFG_DATA_W-1:0] RE_DEFAULT = 32'd100663296;
    localparam logic [CFG_DATA_W-1:0] IM_DEFAULT = 32'd67108864;
    localparam logic [CFG_DATA_W-1:0] OFFS_TOP   = 32'h3FFF_FFFF;
    localparam logic [CFG_DATA_W-1:0] OFFS_BOT   = 32'h4000_0000;
    localparam logic [CFG_DATA_W-1:0] PLUS_EIGHT = 32'h2000_0000;
    localparam logic [CFG_DATA_W-1:0] MINUS_EIGHT = 32'hE000_0000;
    localparam longint unsigned ESCAPE_Q = 64'd4 << FRAC_BITS;

    typedef struct {
        logic [COORD_W-1:0]  col;
        logic [COORD_W-1:0]  row;
        logic [COLOUR_W-1:0] colour;
        logic                in_set;
    } pixel_colour_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [COORD_W-1:0]    s_pixel_column;
    logic [COORD_W-1:0]    s_pixel_row;
    logic                  m_valid;
    logic                  m_ready;
    logic [COLOUR_W-1:0]   m_colour_code;
    logic                  m_in_set;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cfg_t          active_cfg;
    pixel_colour_t pending_colours[$];
    int            mismatch_count = 0;
    int            src_gap_max = 3;
    int            dst_gap_max = 3;
    int            result_hold_cycles = 0;

    mandelbrot_escape_time_pixel_core uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pixel_column (s_pixel_column),
        .s_pixel_row    (s_pixel_row),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_colour_code  (m_colour_code),
        .m_in_set       (m_in_set),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic longint to_word(input longint v);
        logic signed [WORD_W-1:0] w;
        w = v[WORD_W-1:0];
        return longint'(w);
    endfunction

    function automatic longint unsigned square_q(input longint v);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : v;
        return (m * m) >> FRAC_BITS;
    endfunction

    function automatic longint point_coord(input logic [COORD_W-1:0] idx,
                                           input logic [DIM_W-1:0] dim,
                                           input logic [OFFS_W-1:0] offs);
        longint unsigned d;
        longint unsigned num;
        logic signed [OFFS_W-1:0] so;
        d = 64'(dim);
        if (d == 0) d = 1;
        if (d > MAX_DIM) d = MAX_DIM;
        num = 64'(idx) << (FRAC_BITS + 1);
        so = offs;
        return to_word(longint'(num / d) - longint'(so));
    endfunction

    function automatic pixel_colour_t escape_colour(input logic [COORD_W-1:0] col,
                                                    input logic [COORD_W-1:0] row);
        longint cre, cim, x, y, xy;
        longint unsigned a, b, step, n, top;
        bit escaped;
        pixel_colour_t r;
        cre = point_coord(col, active_cfg.width, active_cfg.offset_re);
        cim = point_coord(row, active_cfg.height, active_cfg.offset_im);
        x = cre;
        y = cim;
        top = 64'(active_cfg.max_iter);
        step = (top == 0) ? 0 : 64'(GAMUT) / top;
        escaped = 1'b0;
        n = 0;
        r.col = col;
        r.row = row;
        r.colour = '0;
        while (!escaped && n <= top) begin
            a = square_q(x);
            b = square_q(y);
            if (a + b > ESCAPE_Q) begin
                escaped = 1'b1;
                r.colour = COLOUR_W'((top - n) * step);
            end else begin
                xy = (x * y) >>> (FRAC_BITS - 1);
                y = to_word(xy + cim);
                x = to_word(longint'(a - b) + cre);
                n++;
            end
        end
        r.in_set = !escaped;
        return r;
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_MAX_ITER:  active_cfg.max_iter  = data[ITER_W-1:0];
            CFG_WIDTH:     active_cfg.width     = data[DIM_W-1:0];
            CFG_HEIGHT:    active_cfg.height    = data[DIM_W-1:0];
            CFG_OFFSET_RE: active_cfg.offset_re = data[OFFS_W-1:0];
            CFG_OFFSET_IM: active_cfg.offset_im = data[OFFS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] max_iter,
                                  input logic [CFG_DATA_W-1:0] width,
                                  input logic [CFG_DATA_W-1:0] height,
                                  input logic [CFG_DATA_W-1:0] offs_re,
                                  input logic [CFG_DATA_W-1:0] offs_im);
        write_reg(CFG_MAX_ITER, max_iter);
        write_reg(CFG_WIDTH, width);
        write_reg(CFG_HEIGHT, height);
        write_reg(CFG_OFFSET_RE, offs_re);
        write_reg(CFG_OFFSET_IM, offs_im);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_pixel_column <= col;
        s_pixel_row    <= row;
        do @(posedge aclk); while (!s_ready);
        pending_colours.push_back(escape_colour(col, row));
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_colours.size() != 0);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_dimension();
        logic [CFG_DATA_W-1:0] d;
        case ($urandom_range(0, 9))
            0:       d = 0;
            1:       d = $urandom_range(MAX_DIM + 1, 8191);
            2:       d = MAX_DIM;
            default: d = $urandom_range(2, MAX_DIM);
        endcase
        d[CFG_DATA_W-1:DIM_W] = (CFG_DATA_W-DIM_W)'($urandom);
        return d;
    endfunction

    task automatic test_reset_settings();
        send_pixel(0, 0);
        send_pixel(320, 240);
        send_pixel(4095, 4095);
        send_pixel(4095, 0);
        send_pixel(0, 4095);
        wait_for_results();
    endtask

    task automatic test_iteration_limits();
        apply_settings(65535, MAX_DIM, MAX_DIM, RE_DEFAULT, IM_DEFAULT);
        send_pixel(0, 0);
        send_pixel(2048, 2048);
        wait_for_results();
        apply_settings(1, 640, 480, RE_DEFAULT, IM_DEFAULT);
        send_pixel(0, 0);
        send_pixel(320, 240);
        wait_for_results();
        apply_settings(0, 640, 480, RE_DEFAULT, IM_DEFAULT);
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        wait_for_results();
    endtask

    task automatic test_resolution_limits();
        apply_settings(32, 0, 0, RE_DEFAULT, IM_DEFAULT);
        send_pixel(0, 0);
        send_pixel(1, 1);
        send_pixel(4095, 4095);
        wait_for_results();
        apply_settings(32, 8191, 4097, RE_DEFAULT, IM_DEFAULT);
        send_pixel(4095, 4095);
        send_pixel(2048, 1024);
        wait_for_results();
        apply_settings(32, 2, 2, RE_DEFAULT, IM_DEFAULT);
        send_pixel(1, 1);
        send_pixel(0, 1);
        wait_for_results();
    endtask

    task automatic test_offset_limits();
        apply_settings(32, 640, 480, OFFS_TOP, OFFS_BOT);
        send_pixel(0, 0);
        send_pixel(639, 479);
        wait_for_results();
        apply_settings(32, 640, 480, OFFS_BOT, OFFS_TOP);
        send_pixel(0, 0);
        wait_for_results();
        apply_settings(32, 640, 480, PLUS_EIGHT, MINUS_EIGHT);
        send_pixel(100, 100);
        wait_for_results();
        apply_settings(32, 640, 480, MINUS_EIGHT, PLUS_EIGHT);
        send_pixel(4095, 0);
        wait_for_results();
    endtask

    task automatic test_random_pixels();
        int phase, i, w_eff, h_eff;
        logic [CFG_DATA_W-1:0] d_max, d_w, d_h, d_re, d_im;
        logic [COORD_W-1:0] col, row;
        for (phase = 0; phase < 20; phase++) begin
            case ($urandom_range(0, 19))
                0:       d_max = 0;
                1:       d_max = $urandom_range(49, 200);
                default: d_max = $urandom_range(1, 48);
            endcase
            d_max[CFG_DATA_W-1:ITER_W] = (CFG_DATA_W-ITER_W)'($urandom);
            d_w = pick_dimension();
            d_h = pick_dimension();
            if ($urandom_range(0, 7) == 0) begin
                d_re = $urandom;
            end else begin
                d_re = $urandom_range(ONE_Q / 2, 5 * ONE_Q / 2);
                d_re[CFG_DATA_W-1] = 1'($urandom);
            end
            if ($urandom_range(0, 7) == 0) begin
                d_im = $urandom;
            end else begin
                d_im = 32'(int'($urandom_range(0, 5 * ONE_Q / 2)) - ONE_Q / 2);
                d_im[CFG_DATA_W-1] = 1'($urandom);
            end
            apply_settings(d_max, d_w, d_h, d_re, d_im);
            w_eff = (d_w[DIM_W-1:0] == 0) ? 1 : (d_w[DIM_W-1:0] > MAX_DIM) ? MAX_DIM
                    : int'(d_w[DIM_W-1:0]);
            h_eff = (d_h[DIM_W-1:0] == 0) ? 1 : (d_h[DIM_W-1:0] > MAX_DIM) ? MAX_DIM
                    : int'(d_h[DIM_W-1:0]);
            src_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
            dst_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
            for (i = 0; i < 100; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    col = COORD_W'($urandom);
                    row = COORD_W'($urandom);
                end else begin
                    col = COORD_W'($urandom_range(0, w_eff - 1));
                    row = COORD_W'($urandom_range(0, h_eff - 1));
                end
                send_pixel(col, row);
            end
            wait_for_results();
        end
        src_gap_max = 3;
        dst_gap_max = 3;
    endtask

    task automatic test_output_backpressure();
        int i;
        apply_settings(8, 64, 64, RE_DEFAULT, IM_DEFAULT);
        src_gap_max = 0;
        result_hold_cycles = 3000;
        for (i = 0; i < 12; i++) begin
            send_pixel(COORD_W'($urandom_range(0, 63)), COORD_W'($urandom_range(0, 63)));
        end
        wait_for_results();
        src_gap_max = 3;
    endtask

    initial begin : result_sink
        int pause;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (result_hold_cycles > 0) begin
                pause = result_hold_cycles;
                result_hold_cycles = 0;
                m_ready <= 1'b0;
                repeat (pause) @(posedge aclk);
            end
            pause = $urandom_range(0, dst_gap_max);
            if (pause > 0) begin
                m_ready <= 1'b0;
                repeat (pause) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin : colour_check
        pixel_colour_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_colours.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result with no pixel pending: colour %06h in_set %0b",
                             m_colour_code, m_in_set);
            end else begin
                want = pending_colours.pop_front();
                if (m_colour_code !== want.colour || m_in_set !== want.in_set) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("pixel (%0d,%0d): expected colour %06h in_set %0b, got %06h %0b",
                                 want.col, want.row, want.colour, want.in_set,
                                 m_colour_code, m_in_set);
                end
            end
        end
    end

    initial begin : watchdog
        #100_000_000;
        $display("mandelbrot_escape_time_pixel_core: mismatch");
        $finish;
    end

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_pixel_column = '0;
        s_pixel_row    = '0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_MAX_ITER;
        cfg_data       = '0;
        active_cfg.max_iter  = RST_MAX_ITER;
        active_cfg.width     = RST_WIDTH;
        active_cfg.height    = RST_HEIGHT;
        active_cfg.offset_re = RST_OFFSET_RE;
        active_cfg.offset_im = RST_OFFSET_IM;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_settings();
        test_iteration_limits();
        test_resolution_limits();
        test_offset_limits();
        test_output_backpressure();
        test_random_pixels();
        repeat (400) @(posedge aclk);
        if (mismatch_count == 0 && pending_colours.size() == 0) begin
            $display("mandelbrot_escape_time_pixel_core: match");
        end else begin
            $display("mandelbrot_escape_time_pixel_core: mismatch");
        end
        $finish;
    end

endmodule
